[hdl/dfr_pkg.sv]
package dfr_pkg;

   localparam int FRAME_LEN = 41;
   localparam int FRM_AW    = 6;
   localparam int TXT_DEPTH = 32;
   localparam int TXT_AW    = 5;

   localparam logic [7:0]  HEADER_BYTE = 8'h02;
   localparam logic [15:0] CHK_INIT    = 16'hFFFF;
   localparam logic [7:0]  PRINT_LO    = 8'h20;
   localparam logic [7:0]  PRINT_HI    = 8'h7E;
   localparam logic [6:0]  STAR_CODE   = 7'd42;

   localparam logic [5:0] SUM_IDX     = 6'd39;
   localparam logic [5:0] LAST_IDX    = 6'd40;
   localparam logic [5:0] FRAME_END   = 6'd41;
   localparam logic [5:0] LINE0_START = 6'd6;
   localparam logic [5:0] LINE0_END   = 6'd21;
   localparam logic [5:0] LINE1_START = 6'd23;
   localparam logic [5:0] LINE1_END   = 6'd38;
   localparam logic [3:0] POS_LAST    = 4'd15;

   typedef struct packed {
      logic              we;
      logic [FRM_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [FRM_AW-1:0] raddr;
   } frm_port_type;

   typedef struct packed {
      logic              we;
      logic [TXT_AW-1:0] waddr;
      logic [6:0]        wdata;
      logic              re;
      logic [TXT_AW-1:0] raddr;
   } txt_port_type;

   typedef struct packed {
      logic start;
      logic acc;
      logic hold_hi;
   } sum_ctl_type;

   typedef struct packed {
      logic              hit;
      logic              line;
      logic [TXT_AW-1:0] idx;
   } text_map_type;

   function automatic logic [6:0] clean_char(input logic [7:0] b);
      return (b >= PRINT_LO && b <= PRINT_HI) ? b[6:0] : STAR_CODE;
   endfunction

   // frame byte address to emitted text slot
   function automatic text_map_type text_map(input logic [FRM_AW-1:0] a);
      text_map_type m;
      logic [FRM_AW-1:0] d0;
      logic [FRM_AW-1:0] d1;
      d0 = a - LINE0_START;
      d1 = a - LINE1_START;
      m.hit  = 1'b0;
      m.line = 1'b0;
      m.idx  = '0;
      if (a >= LINE0_START && a <= LINE0_END) begin
         m.hit = 1'b1;
         m.idx = {1'b0, d0[3:0]};
      end else if (a >= LINE1_START && a <= LINE1_END) begin
         m.hit  = 1'b1;
         m.line = 1'b1;
         m.idx  = {1'b1, d1[3:0]};
      end
      return m;
   endfunction

   // character slot {line, position} to frame byte address
   function automatic logic [FRM_AW-1:0] line_addr(input logic [TXT_AW-1:0] c);
      return c[4] ? (LINE1_START + {2'b00, c[3:0]}) : (LINE0_START + {2'b00, c[3:0]});
   endfunction

endpackage

[hdl/dfr_ram.sv]
module dfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 41
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/dfr_sum.sv]
module dfr_sum (
   input  logic                 clock,
   input  dfr_pkg::sum_ctl_type ctl,
   input  logic [7:0]           rx_byte,
   output logic                 match
);

   logic [15:0] chk_ff;
   logic [15:0] chk_in;
   logic [7:0]  hi_ff;
   logic [7:0]  hi_in;

   // subtracts one byte per beat from the running check value
   always_comb begin
      chk_in = chk_ff;
      hi_in  = hi_ff;
      if (ctl.start) begin
         chk_in = dfr_pkg::CHK_INIT - {8'h00, rx_byte};
      end else if (ctl.acc) begin
         chk_in = chk_ff - {8'h00, rx_byte};
      end
      if (ctl.hold_hi) begin
         hi_in = rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff <= chk_in;
      hi_ff  <= hi_in;
   end

   assign match = (chk_ff == {hi_ff, rx_byte});

endmodule

[hdl/dfr_ctrl.sv]
module dfr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_line_number,
   output logic [3:0]            rsp_char_position,
   output logic [6:0]            rsp_char_code,
   output logic                  rsp_last_of_run,
   output dfr_pkg::sum_ctl_type  sum_ctl,
   input  logic                  sum_match,
   output dfr_pkg::frm_port_type frm_port,
   input  logic [7:0]            frm_rd,
   output dfr_pkg::frm_port_type prv_port,
   input  logic [7:0]            prv_rd,
   output dfr_pkg::txt_port_type txt_port,
   input  logic [6:0]            txt_rd
);

   typedef enum logic [3:0] {
      ST_RX     = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_EFETCH = 4'b0100,
      ST_EOUT   = 4'b1000
   } state_type;

   state_type                             state_ff, state_in;
   logic [dfr_pkg::FRM_AW-1:0]            cnt_ff, cnt_in;
   logic [dfr_pkg::FRM_AW-1:0]            sa_ff, sa_in;
   logic [dfr_pkg::FRM_AW-1:0]            pa_ff, pa_in;
   logic                                  pv_ff, pv_in;
   logic                                  pvq_ff, pvq_in;
   logic [dfr_pkg::FRAME_LEN-1:0]         prev_vld_ff, prev_vld_in;
   logic                                  fdiff_ff, fdiff_in;
   logic                                  d0_ff, d0_in;
   logic                                  d1_ff, d1_in;
   logic [1:0]                            flags_ff, flags_in;
   logic                                  e1_ff, e1_in;
   logic [dfr_pkg::TXT_AW-1:0]            ec_ff, ec_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  rsp_ln_ff, rsp_ln_in;
   logic [3:0]                            rsp_pos_ff, rsp_pos_in;
   logic [6:0]                            rsp_code_ff, rsp_code_in;
   logic                                  rsp_last_ff, rsp_last_in;

   always_comb begin
      dfr_pkg::text_map_type      lm_sa;
      dfr_pkg::text_map_type      lm_pa;
      logic [7:0]                 pb;
      logic [6:0]                 cb;
      logic                       fdiff_now;
      logic                       e0;
      logic                       e1;
      logic                       ec_last;
      logic [dfr_pkg::TXT_AW-1:0] ec_nxt;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sa_in        = sa_ff;
      pa_in        = pa_ff;
      pv_in        = 1'b0;
      pvq_in       = pvq_ff;
      prev_vld_in  = prev_vld_ff;
      fdiff_in     = fdiff_ff;
      d0_in        = d0_ff;
      d1_in        = d1_ff;
      flags_in     = flags_ff;
      e1_in        = e1_ff;
      ec_in        = ec_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ln_in    = rsp_ln_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      sum_ctl      = '0;
      frm_port     = '0;
      prv_port     = '0;
      txt_port     = '0;

      lm_sa     = dfr_pkg::text_map(sa_ff);
      lm_pa     = dfr_pkg::text_map(pa_ff);
      pb        = pvq_ff ? prv_rd : 8'h00;
      cb        = dfr_pkg::clean_char(frm_rd);
      fdiff_now = fdiff_ff | (frm_rd != pb);
      e0        = !flags_ff[0] || d0_ff;
      e1        = !flags_ff[1] || d1_ff;
      ec_last   = (ec_ff[3:0] == dfr_pkg::POS_LAST) && (ec_ff[4] || !e1_ff);
      ec_nxt    = (ec_ff[3:0] == dfr_pkg::POS_LAST) ? {1'b1, 4'd0} : (ec_ff + 5'd1);

      case (state_ff)
         ST_RX: begin
            if (req_valid && !(cnt_ff == '0 && req_rx_byte != dfr_pkg::HEADER_BYTE)) begin
               frm_port.we    = 1'b1;
               frm_port.waddr = cnt_ff;
               frm_port.wdata = req_rx_byte;
               if (cnt_ff == '0) begin
                  sum_ctl.start = 1'b1;
               end else if (cnt_ff < dfr_pkg::SUM_IDX) begin
                  sum_ctl.acc = 1'b1;
               end else if (cnt_ff == dfr_pkg::SUM_IDX) begin
                  sum_ctl.hold_hi = 1'b1;
               end
               if (cnt_ff == dfr_pkg::LAST_IDX) begin
                  cnt_in = '0;
                  if (sum_match) begin
                     state_in = ST_SCAN;
                     sa_in    = '0;
                     fdiff_in = 1'b0;
                     d0_in    = 1'b0;
                     d1_in    = 1'b0;
                  end
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
         end
         ST_SCAN: begin
            // issue side
            if (sa_ff != dfr_pkg::FRAME_END) begin
               frm_port.re    = 1'b1;
               frm_port.raddr = sa_ff;
               prv_port.re    = 1'b1;
               prv_port.raddr = sa_ff;
               txt_port.re    = lm_sa.hit;
               txt_port.raddr = lm_sa.idx;
               pvq_in         = prev_vld_ff[sa_ff];
               pv_in          = 1'b1;
               pa_in          = sa_ff;
               sa_in          = sa_ff + 6'd1;
            end
            // return side, for the read issued the beat before
            if (pv_ff) begin
               prv_port.we         = 1'b1;
               prv_port.waddr      = pa_ff;
               prv_port.wdata      = frm_rd;
               prev_vld_in[pa_ff]  = 1'b1;
               fdiff_in            = fdiff_now;
               if (lm_pa.hit) begin
                  txt_port.we    = 1'b1;
                  txt_port.waddr = lm_pa.idx;
                  txt_port.wdata = cb;
                  if (cb != txt_rd) begin
                     if (lm_pa.line) begin
                        d1_in = 1'b1;
                     end else begin
                        d0_in = 1'b1;
                     end
                  end
               end
               if (pa_ff == dfr_pkg::LAST_IDX) begin
                  if (!fdiff_now) begin
                     state_in = ST_RX;
                  end else begin
                     flags_in = flags_ff | {e1, e0};
                     e1_in    = e1;
                     ec_in    = e0 ? 5'd0 : 5'd16;
                     state_in = (e0 || e1) ? ST_EFETCH : ST_RX;
                  end
               end
            end
         end
         ST_EFETCH: begin
            frm_port.re    = 1'b1;
            frm_port.raddr = dfr_pkg::line_addr(ec_ff);
            state_in       = ST_EOUT;
         end
         ST_EOUT: begin
            if (rsp_valid_ff && rsp_ready && rsp_last_ff) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_RX;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ln_in    = ec_ff[4];
               rsp_pos_in   = ec_ff[3:0];
               rsp_code_in  = cb;
               rsp_last_in  = ec_last;
               if (!ec_last) begin
                  ec_in          = ec_nxt;
                  frm_port.re    = 1'b1;
                  frm_port.raddr = dfr_pkg::line_addr(ec_nxt);
               end
            end
         end
         default: begin
            state_in = ST_RX;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RX;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         prev_vld_ff  <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         prev_vld_ff  <= prev_vld_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff       <= sa_in;
      pa_ff       <= pa_in;
      pvq_ff      <= pvq_in;
      fdiff_ff    <= fdiff_in;
      d0_ff       <= d0_in;
      d1_ff       <= d1_in;
      e1_ff       <= e1_in;
      ec_ff       <= ec_in;
      rsp_ln_ff   <= rsp_ln_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready         = (state_ff == ST_RX);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_number   = rsp_ln_ff;
   assign rsp_char_position = rsp_pos_ff;
   assign rsp_char_code     = rsp_code_ff;
   assign rsp_last_of_run   = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_rsp_while_rx: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("result pending while taking bytes");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_of_run) |=> req_ready)
      else $error("run did not end after final character");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= dfr_pkg::LAST_IDX)
      else $error("byte count past frame length");
   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> (state_ff == ST_SCAN && pa_ff <= dfr_pkg::LAST_IDX))
      else $error("scan return outside frame");
   a_flags_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> flags_ff[rsp_line_number])
      else $error("line emitted without its flag");
`endif

endmodule

[hdl/display_frame_receiver_unit.sv]
// channel  | ports                                    | handshake
// req      | req_rx_byte[7:0]                         | req_valid / req_ready
// rsp      | rsp_line_number, rsp_char_position[3:0], | rsp_valid / rsp_ready
//          | rsp_char_code[6:0], rsp_last_of_run      |
//
// every byte of a frame, and every dropped byte, is taken without a stall
// after the last byte of a valid frame ready drops for a scan of the
// frame store (one ram read a cycle, each read handled on its return), then, when a line is shown,
// a fetch step, a load step and then one character per cycle while rsp_ready is high
// reset clears the previous-frame valid bits at once, so there is no clearing pass
// a stalled rsp beat holds in the output register; ready stays low until the run ends
module display_frame_receiver_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_line_number,
   output logic [3:0] rsp_char_position,
   output logic [6:0] rsp_char_code,
   output logic       rsp_last_of_run
);

   dfr_pkg::sum_ctl_type  sum_ctl;
   logic                  sum_match;
   dfr_pkg::frm_port_type frm_port;
   dfr_pkg::frm_port_type prv_port;
   dfr_pkg::txt_port_type txt_port;
   logic [7:0]            frm_rd;
   logic [7:0]            prv_rd;
   logic [6:0]            txt_rd;

   dfr_sum u_sum (
      .clock   (clock),
      .ctl     (sum_ctl),
      .rx_byte (req_rx_byte),
      .match   (sum_match)
   );

   dfr_ram #(.WIDTH(8), .DEPTH(dfr_pkg::FRAME_LEN)) u_frame_ram (
      .clock (clock),
      .we    (frm_port.we),
      .waddr (frm_port.waddr),
      .wdata (frm_port.wdata),
      .re    (frm_port.re),
      .raddr (frm_port.raddr),
      .rdata (frm_rd)
   );

   dfr_ram #(.WIDTH(8), .DEPTH(dfr_pkg::FRAME_LEN)) u_prev_ram (
      .clock (clock),
      .we    (prv_port.we),
      .waddr (prv_port.waddr),
      .wdata (prv_port.wdata),
      .re    (prv_port.re),
      .raddr (prv_port.raddr),
      .rdata (prv_rd)
   );

   dfr_ram #(.WIDTH(7), .DEPTH(dfr_pkg::TXT_DEPTH)) u_text_ram (
      .clock (clock),
      .we    (txt_port.we),
      .waddr (txt_port.waddr),
      .wdata (txt_port.wdata),
      .re    (txt_port.re),
      .raddr (txt_port.raddr),
      .rdata (txt_rd)
   );

   dfr_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_number   (rsp_line_number),
      .rsp_char_position (rsp_char_position),
      .rsp_char_code     (rsp_char_code),
      .rsp_last_of_run   (rsp_last_of_run),
      .sum_ctl           (sum_ctl),
      .sum_match         (sum_match),
      .frm_port          (frm_port),
      .frm_rd            (frm_rd),
      .prv_port          (prv_port),
      .prv_rd            (prv_rd),
      .txt_port          (txt_port),
      .txt_rd            (txt_rd)
   );

endmodule
